[design/sphere_sphere_intersect_macros.svh]
// Assertion macros used by the checker file.
`ifndef SPHERE_SPHERE_INTERSECT_MACROS_SVH
`define SPHERE_SPHERE_INTERSECT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SSSI_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sssi assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SSSI_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sssi assertion failed");

// A condition that must hold at every edge, reset included.
`define SSSI_ASSERT_ALWAYS(lbl, clk, cond) \
   lbl: assert property (@(posedge clk) (cond)) \
      else $error("sssi assertion failed");

`endif

[design/sssi_pkg.sv]
package sssi_pkg;

   localparam int CW = 32;
   localparam int DM = CW + 1;
   localparam int LW = DM + 1;
   localparam int SW = 2 * LW;
   localparam int GM = LW;
   localparam int QW = GM;
   localparam int PW = DM + GM;
   localparam int RW = LW + 2;
   localparam int LATENCY = 3 + LW + 2 + QW + 1;

   typedef logic [CW-1:0] coord_type;
   typedef logic [CW-2:0] radius_type;

   typedef struct packed {
      logic [2:0][DM-1:0] dmag;
      logic [2:0]         dneg;
      logic [CW-1:0]      rsum;
   } front_type;

   typedef struct packed {
      logic [2:0] neg;
      logic       hit;
      logic       degen;
   } div_side_type;

endpackage

[design/sssi_if.sv]
interface sssi_req_if;
   import sssi_pkg::*;
   logic       valid;
   logic       ready;
   coord_type  a_center_x;
   coord_type  a_center_y;
   coord_type  a_center_z;
   radius_type a_radius;
   coord_type  b_center_x;
   coord_type  b_center_y;
   coord_type  b_center_z;
   radius_type b_radius;
   modport source (output valid, a_center_x, a_center_y, a_center_z, a_radius,
      b_center_x, b_center_y, b_center_z, b_radius, input ready);
   modport sink (input valid, a_center_x, a_center_y, a_center_z, a_radius,
      b_center_x, b_center_y, b_center_z, b_radius, output ready);
   modport monitor (input valid, ready, a_center_x, a_center_y, a_center_z,
      a_radius, b_center_x, b_center_y, b_center_z, b_radius);
endinterface

interface sssi_rsp_if;
   import sssi_pkg::*;
   logic      valid;
   logic      ready;
   logic      hit;
   coord_type gap_x;
   coord_type gap_y;
   coord_type gap_z;
   logic      degenerate;
   modport source (output valid, hit, gap_x, gap_y, gap_z, degenerate, input ready);
   modport sink (input valid, hit, gap_x, gap_y, gap_z, degenerate, output ready);
   modport monitor (input valid, ready, hit, gap_x, gap_y, gap_z, degenerate);
endinterface

[design/sssi_front.sv]
module sssi_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   adv,
   input  logic                   in_valid,
   input  sssi_pkg::coord_type    a_x,
   input  sssi_pkg::coord_type    a_y,
   input  sssi_pkg::coord_type    a_z,
   input  sssi_pkg::radius_type   a_r,
   input  sssi_pkg::coord_type    b_x,
   input  sssi_pkg::coord_type    b_y,
   input  sssi_pkg::coord_type    b_z,
   input  sssi_pkg::radius_type   b_r,
   output logic                   out_valid,
   output logic [sssi_pkg::SW-1:0] out_s,
   output sssi_pkg::front_type    out_side
);
   import sssi_pkg::*;

   logic [2:0]         v_ff;
   logic [2:0][DM-1:0] d_ff;
   logic [CW-1:0]      rsum1_ff;
   logic [2:0][2*DM-1:0] sq_ff;
   front_type          side2_ff;
   front_type          side3_ff;
   logic [SW-1:0]      s_ff;
   logic [2:0][DM-1:0] d_in;
   front_type          side2_in;
   logic [2:0][2*DM-1:0] sq_in;

   always_comb begin
      d_in[0] = {b_x[CW-1], b_x} - {a_x[CW-1], a_x};
      d_in[1] = {b_y[CW-1], b_y} - {a_y[CW-1], a_y};
      d_in[2] = {b_z[CW-1], b_z} - {a_z[CW-1], a_z};
      side2_in.rsum = rsum1_ff;
      for (int i = 0; i < 3; i++) begin
         side2_in.dneg[i] = d_ff[i][DM-1];
         side2_in.dmag[i] = d_ff[i][DM-1] ? (~d_ff[i] + 1'b1) : d_ff[i];
         sq_in[i] = side2_in.dmag[i] * side2_in.dmag[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[1:0], in_valid};
      end
      if (adv) begin
         d_ff     <= d_in;
         rsum1_ff <= {1'b0, a_r} + {1'b0, b_r};
         sq_ff    <= sq_in;
         side2_ff <= side2_in;
         side3_ff <= side2_ff;
         s_ff     <= {2'b00, sq_ff[0]} + {2'b00, sq_ff[1]} + {2'b00, sq_ff[2]};
      end
   end

   assign out_valid = v_ff[2];
   assign out_s     = s_ff;
   assign out_side  = side3_ff;
endmodule

[design/sssi_sqrt.sv]
module sssi_sqrt (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    adv,
   input  logic                    in_valid,
   input  logic [sssi_pkg::SW-1:0] in_s,
   input  sssi_pkg::front_type     in_side,
   output logic                    out_valid,
   output logic [sssi_pkg::LW-1:0] out_len,
   output sssi_pkg::front_type     out_side
);
   import sssi_pkg::*;

   logic      v_ff    [0:LW];
   logic [RW-1:0] rem_ff  [0:LW];
   logic [LW-1:0] root_ff [0:LW];
   logic [SW-1:0] s_ff    [0:LW];
   front_type side_ff [0:LW];

   always_comb begin
      v_ff[0]    = in_valid;
      rem_ff[0]  = '0;
      root_ff[0] = '0;
      s_ff[0]    = in_s;
      side_ff[0] = in_side;
   end

   for (genvar k = 1; k <= LW; k++) begin : g_stage
      logic [RW-1:0] rem_in;
      logic [RW-1:0] trial;
      logic          take;
      always_comb begin
         rem_in = {rem_ff[k-1][RW-3:0], s_ff[k-1][SW-1:SW-2]};
         trial  = {root_ff[k-1], 2'b01};
         take   = rem_in >= trial;
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (adv) begin
            v_ff[k] <= v_ff[k-1];
         end
         if (adv) begin
            rem_ff[k]  <= take ? (rem_in - trial) : rem_in;
            root_ff[k] <= {root_ff[k-1][LW-2:0], take};
            s_ff[k]    <= {s_ff[k-1][SW-3:0], 2'b00};
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   assign out_valid = v_ff[LW];
   assign out_len   = root_ff[LW];
   assign out_side  = side_ff[LW];
endmodule

[design/sssi_div.sv]
module sssi_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic                          in_valid,
   input  logic [2:0][sssi_pkg::PW-1:0]  in_num,
   input  logic [sssi_pkg::LW-1:0]       in_den,
   input  sssi_pkg::div_side_type        in_side,
   output logic                          out_valid,
   output logic [2:0][sssi_pkg::QW-1:0]  out_quot,
   output sssi_pkg::div_side_type        out_side
);
   import sssi_pkg::*;

   logic               v_ff    [0:QW];
   logic [2:0][LW-1:0] rem_ff  [0:QW];
   logic [2:0][QW-1:0] low_ff  [0:QW];
   logic [LW-1:0]      den_ff  [0:QW];
   div_side_type       side_ff [0:QW];

   always_comb begin
      v_ff[0]    = in_valid;
      den_ff[0]  = in_den;
      side_ff[0] = in_side;
      for (int i = 0; i < 3; i++) begin
         rem_ff[0][i] = LW'(in_num[i][PW-1:QW]);
         low_ff[0][i] = in_num[i][QW-1:0];
      end
   end

   for (genvar k = 1; k <= QW; k++) begin : g_stage
      logic [2:0][LW:0]   rem_in;
      logic [2:0]         take;
      logic [2:0][LW-1:0] rem_nx;
      logic [2:0][QW-1:0] low_nx;
      always_comb begin
         for (int i = 0; i < 3; i++) begin
            rem_in[i] = {rem_ff[k-1][i], low_ff[k-1][i][QW-1]};
            take[i]   = rem_in[i] >= {1'b0, den_ff[k-1]};
            rem_nx[i] = take[i] ? LW'(rem_in[i] - {1'b0, den_ff[k-1]})
                                : rem_in[i][LW-1:0];
            low_nx[i] = {low_ff[k-1][i][QW-2:0], take[i]};
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (adv) begin
            v_ff[k] <= v_ff[k-1];
         end
         if (adv) begin
            rem_ff[k]  <= rem_nx;
            low_ff[k]  <= low_nx;
            den_ff[k]  <= den_ff[k-1];
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   assign out_valid = v_ff[QW];
   assign out_quot  = low_ff[QW];
   assign out_side  = side_ff[QW];
endmodule

[design/sphere_sphere_intersect.sv]
// Channel  Direction  Contents
// req_ch   in         two sphere centers and radii, one pair per item
// rsp_ch   out        hit, gap vector and degenerate flag, one per item
//
// One item enters every cycle unless a stall on rsp_ch holds the pipeline.
// The pipeline includes the 34-stage square root and the 34-stage divider.
// Reset clears all valid bits; payload registers are not reset.
// A stall on rsp_ch freezes the whole pipeline and drops req_ch.ready.
module sphere_sphere_intersect (
   input logic      clock,
   input logic      reset,
   sssi_req_if.sink   req_ch,
   sssi_rsp_if.source rsp_ch
);
   import sssi_pkg::*;

   logic          adv;
   logic          f_valid;
   logic [SW-1:0] f_s;
   front_type     f_side;
   logic          q_valid;
   logic [LW-1:0] q_len;
   front_type     q_side;

   logic          g_v_ff;
   front_type     g_side_ff;
   logic [GM-1:0] g_mag_ff;
   logic          g_neg_ff;
   logic [LW-1:0] g_len_ff;
   logic          g_hit_ff;
   logic          g_degen_ff;
   logic [LW:0]   gap_in;

   logic               m_v_ff;
   logic [2:0][PW-1:0] m_prod_ff;
   logic [LW-1:0]      m_len_ff;
   div_side_type       m_side_ff;
   div_side_type       m_side_in;

   logic               d_valid;
   logic [2:0][QW-1:0] d_quot;
   div_side_type       d_side;

   logic               o_v_ff;
   logic               o_hit_ff;
   logic               o_degen_ff;
   logic [2:0][CW-1:0] o_gap_ff;
   logic [2:0][CW-1:0] o_gap_in;

   assign adv = !o_v_ff || rsp_ch.ready;
   assign req_ch.ready = adv;

   sssi_front u_front (
      .clock(clock), .reset(reset), .adv(adv), .in_valid(req_ch.valid),
      .a_x(req_ch.a_center_x), .a_y(req_ch.a_center_y), .a_z(req_ch.a_center_z),
      .a_r(req_ch.a_radius),
      .b_x(req_ch.b_center_x), .b_y(req_ch.b_center_y), .b_z(req_ch.b_center_z),
      .b_r(req_ch.b_radius),
      .out_valid(f_valid), .out_s(f_s), .out_side(f_side)
   );

   sssi_sqrt u_sqrt (
      .clock(clock), .reset(reset), .adv(adv), .in_valid(f_valid), .in_s(f_s),
      .in_side(f_side), .out_valid(q_valid), .out_len(q_len), .out_side(q_side)
   );

   always_comb begin
      gap_in = {1'b0, q_len} - {(LW + 1 - CW)'(0), q_side.rsum};
      for (int i = 0; i < 3; i++) begin
         m_side_in.neg[i] = g_side_ff.dneg[i] ^ g_neg_ff;
      end
      m_side_in.hit   = g_hit_ff;
      m_side_in.degen = g_degen_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         g_v_ff <= 1'b0;
         m_v_ff <= 1'b0;
      end else if (adv) begin
         g_v_ff <= q_valid;
         m_v_ff <= g_v_ff;
      end
      if (adv) begin
         g_side_ff  <= q_side;
         g_neg_ff   <= gap_in[LW];
         g_mag_ff   <= gap_in[LW] ? GM'(~gap_in + 1'b1) : GM'(gap_in);
         g_len_ff   <= q_len;
         g_hit_ff   <= q_len < {(LW - CW)'(0), q_side.rsum};
         g_degen_ff <= q_len == '0;
         for (int i = 0; i < 3; i++) begin
            m_prod_ff[i] <= g_side_ff.dmag[i] * g_mag_ff;
         end
         m_len_ff  <= g_len_ff;
         m_side_ff <= m_side_in;
      end
   end

   sssi_div u_div (
      .clock(clock), .reset(reset), .adv(adv), .in_valid(m_v_ff),
      .in_num(m_prod_ff), .in_den(m_len_ff), .in_side(m_side_ff),
      .out_valid(d_valid), .out_quot(d_quot), .out_side(d_side)
   );

   always_comb begin
      logic [QW-1:0] limit;
      logic [QW-1:0] m;
      logic [QW-1:0] val;
      for (int i = 0; i < 3; i++) begin
         limit = d_side.neg[i] ? (QW'(1) << (CW - 1)) : ((QW'(1) << (CW - 1)) - 1'b1);
         m     = (d_quot[i] > limit) ? limit : d_quot[i];
         val   = d_side.neg[i] ? (~m + 1'b1) : m;
         o_gap_in[i] = d_side.degen ? '0 : val[CW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         o_v_ff <= 1'b0;
      end else if (adv) begin
         o_v_ff <= d_valid;
      end
      if (adv) begin
         o_hit_ff   <= d_side.hit;
         o_degen_ff <= d_side.degen;
         o_gap_ff   <= o_gap_in;
      end
   end

   assign rsp_ch.valid      = o_v_ff;
   assign rsp_ch.hit        = o_hit_ff;
   assign rsp_ch.gap_x      = o_gap_ff[0];
   assign rsp_ch.gap_y      = o_gap_ff[1];
   assign rsp_ch.gap_z      = o_gap_ff[2];
   assign rsp_ch.degenerate = o_degen_ff;
endmodule

[design/sssi_checker.sv]
`include "sphere_sphere_intersect_macros.svh"

module sssi_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic                rsp_hit,
   input sssi_pkg::coord_type rsp_gap_x,
   input sssi_pkg::coord_type rsp_gap_y,
   input sssi_pkg::coord_type rsp_gap_z,
   input logic                rsp_degenerate
);
   `SSSI_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_hit) && $stable(rsp_gap_x) && $stable(rsp_gap_y) && $stable(rsp_gap_z) && $stable(rsp_degenerate))
   `SSSI_ASSERT_IMPLY(a_degen_zero, clock, reset, rsp_valid && rsp_degenerate, rsp_gap_x == '0 && rsp_gap_y == '0 && rsp_gap_z == '0)
   `SSSI_ASSERT_IMPLY(a_ready_flow, clock, reset, !rsp_valid, req_ready)
   `SSSI_ASSERT_NEXT(a_reset_clear, clock, 1'b0, reset, !rsp_valid)
endmodule

bind sphere_sphere_intersect sssi_checker u_sssi_checker (
   .clock(clock), .reset(reset), .req_ready(req_ch.ready),
   .rsp_valid(rsp_ch.valid), .rsp_ready(rsp_ch.ready), .rsp_hit(rsp_ch.hit),
   .rsp_gap_x(rsp_ch.gap_x), .rsp_gap_y(rsp_ch.gap_y), .rsp_gap_z(rsp_ch.gap_z),
   .rsp_degenerate(rsp_ch.degenerate)
);
